// ===== rtl/skgc_pkg.sv =====
package skgc_pkg;

    localparam int LOG_TABLE_BITS_DEF = 8;

    localparam int SAMPLE_W    = 24;
    localparam int DB_W        = 16;
    localparam int RATIO_W     = 13;
    localparam int KNEE_W      = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ROM_W       = 16;
    localparam int SLOPE_W     = 17;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KNEE      = 2'd2;

    localparam logic signed [DB_W-1:0] THRESHOLD_RESET = -16'sd5120;
    localparam int                     RATIO_RESET     = 512;
    localparam logic [KNEE_W-1:0]      KNEE_RESET      = 13'd1536;

    // 20*log10(2) in Q16 and the level floor of -100 dB in Q8.8.
    localparam int DB_PER_OCTAVE = 394566;
    localparam int DB_OCT_W      = 19;
    localparam int DB_SHIFT      = 24;
    localparam int LEVEL_FLOOR   = 25600;

    // Slope magnitude is 1 - 1/ratio in Q16.
    localparam int SLOPE_ONE     = 65536;
    localparam int SLOPE_NUM     = 16777216;
    localparam int SLOPE_DVD_W   = 25;
    localparam int SLOPE_Q_BITS  = 17;
    localparam int RATIO_MIN     = 256;
    localparam int RATIO_LIMIT   = 6119;
    localparam logic [SLOPE_W-1:0] SLOPE_RESET =
        SLOPE_W'(SLOPE_ONE - (SLOPE_NUM + RATIO_RESET / 2) / RATIO_RESET);

    // Largest gain reduction magnitude, -128 dB in Q8.8.
    localparam int GAIN_MAX = 32768;

    typedef struct packed {
        logic               busy;
        logic [SLOPE_W-1:0] mag;
    } slope_stat_t;

    typedef struct packed {
        logic signed [DB_W-1:0] threshold;
        logic [KNEE_W-1:0]      knee;
        logic [SLOPE_W-1:0]     slope;
    } curve_cfg_t;

    // log2(1 + k/2^bits) in Q0.16 by repeated squaring of a Q1.30 value.
    function automatic logic [ROM_W-1:0] log2_entry(input int k, input int bits);
        logic [63:0]      x;
        logic [ROM_W-1:0] frac;
        x    = (64'd1 << 30) + (64'(k) << (30 - bits));
        frac = '0;
        for (int i = 0; i < ROM_W; i++) begin
            x    = (x * x) >> 30;
            frac = {frac[ROM_W-2:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                x       = x >> 1;
            end
        end
        return frac;
    endfunction

endpackage

// ===== rtl/skgc_slope_div.sv =====
module skgc_slope_div
    import skgc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RATIO_W-1:0] ratio,
    output slope_stat_t        stat
);

    localparam int CNT_W = $clog2(SLOPE_Q_BITS + 1);

    logic                    busy_reg;
    logic [SLOPE_W-1:0]      mag_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [RATIO_W-1:0]      div_reg;
    logic [RATIO_W-1:0]      rem_reg;
    logic [SLOPE_Q_BITS-1:0] low_reg;
    logic [SLOPE_Q_BITS-1:0] q_reg;

    logic [RATIO_W-1:0]      r_eff;
    logic                    limit;
    logic [SLOPE_DVD_W-1:0]  dividend;
    logic [RATIO_W:0]        trial;
    logic                    take;
    logic [RATIO_W-1:0]      rem_next;
    logic [SLOPE_Q_BITS-1:0] q_next;

    always_comb begin
        r_eff    = (ratio < RATIO_W'(RATIO_MIN)) ? RATIO_W'(RATIO_MIN) : ratio;
        limit    = (r_eff >= RATIO_W'(RATIO_LIMIT));
        dividend = SLOPE_DVD_W'(SLOPE_NUM) + SLOPE_DVD_W'(r_eff >> 1);
        trial    = {rem_reg, low_reg[SLOPE_Q_BITS-1]};
        take     = (trial >= {1'b0, div_reg});
        rem_next = take ? RATIO_W'(trial - {1'b0, div_reg}) : trial[RATIO_W-1:0];
        q_next   = {q_reg[SLOPE_Q_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mag_reg  <= SLOPE_RESET;
            cnt_reg  <= '0;
        end else if (start) begin
            if (limit) begin
                busy_reg <= 1'b0;
                mag_reg  <= SLOPE_W'(SLOPE_ONE);
            end else begin
                busy_reg <= 1'b1;
            end
            cnt_reg <= CNT_W'(SLOPE_Q_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                mag_reg  <= SLOPE_W'(SLOPE_ONE) - SLOPE_W'(q_next);
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= r_eff;
            rem_reg <= RATIO_W'(dividend[SLOPE_DVD_W-1:SLOPE_Q_BITS]);
            low_reg <= dividend[SLOPE_Q_BITS-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[SLOPE_Q_BITS-2:0], 1'b0};
            q_reg   <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.mag  = mag_reg;

endmodule

// ===== rtl/skgc_level.sv =====
module skgc_level
    import skgc_pkg::*;
#(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DB_W-1:0]     out_level
);

    localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
    localparam int NSTG     = 5;
    localparam int EXP_W    = $clog2(SAMPLE_W);
    localparam int L2_W     = EXP_W + ROM_W;
    localparam int PROD_W   = L2_W + DB_OCT_W;
    localparam int DBM_W    = PROD_W + 1 - DB_SHIFT;

    logic [ROM_W-1:0] log_rom [TBL_SIZE];

    for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
        assign log_rom[g] = log2_entry(g, LOG_TABLE_BITS);
    end

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   adv;

    logic [SAMPLE_W-1:0]       mag_a_reg, mag_a_next;
    logic                      zero_b_reg, zero_b_next;
    logic [EXP_W-1:0]          exp_b_reg, exp_b_next;
    logic [LOG_TABLE_BITS-1:0] k_b_reg, k_b_next;
    logic [SAMPLE_W-1:0]       norm;
    logic                      zero_c_reg;
    logic [L2_W-1:0]           nl2_c_reg, nl2_c_next;
    logic                      zero_d_reg;
    logic [PROD_W-1:0]         prod_d_reg, prod_d_next;
    logic signed [DB_W-1:0]    level_e_reg, level_e_next;
    logic [PROD_W:0]           rnd;
    logic [DBM_W-1:0]          db_mag;
    logic [DB_W-1:0]           lvl_mag;

    always_comb begin
        adv[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        // The most negative sample gives a magnitude of exactly 2^23.
        mag_a_next = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;

        zero_b_next = (mag_a_reg == '0);
        exp_b_next  = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (mag_a_reg[i]) begin
                exp_b_next = EXP_W'(i);
            end
        end
        norm     = mag_a_reg << (EXP_W'(SAMPLE_W - 1) - exp_b_next);
        k_b_next = norm[SAMPLE_W-2 -: LOG_TABLE_BITS];

        // Negated log2 level in Q16; it is never positive before negation.
        nl2_c_next = {EXP_W'(EXP_W'(SAMPLE_W - 1) - exp_b_reg), ROM_W'(0)}
                   - L2_W'(log_rom[k_b_reg]);

        prod_d_next = PROD_W'(nl2_c_reg) * PROD_W'(DB_PER_OCTAVE);

        rnd     = {1'b0, prod_d_reg} + (PROD_W + 1)'(64'd1 << (DB_SHIFT - 1));
        db_mag  = rnd[PROD_W:DB_SHIFT];
        lvl_mag = (zero_d_reg || db_mag > DBM_W'(LEVEL_FLOOR)) ? DB_W'(LEVEL_FLOOR)
                                                               : db_mag[DB_W-1:0];
        level_e_next = ~lvl_mag + DB_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            mag_a_reg <= mag_a_next;
        end
        if (adv[1]) begin
            zero_b_reg <= zero_b_next;
            exp_b_reg  <= exp_b_next;
            k_b_reg    <= k_b_next;
        end
        if (adv[2]) begin
            zero_c_reg <= zero_b_reg;
            nl2_c_reg  <= nl2_c_next;
        end
        if (adv[3]) begin
            zero_d_reg <= zero_c_reg;
            prod_d_reg <= prod_d_next;
        end
        if (adv[4]) begin
            level_e_reg <= level_e_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_level = level_e_reg;

endmodule

// ===== rtl/skgc_curve.sv =====
module skgc_curve
    import skgc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [DB_W-1:0] in_level,
    input  curve_cfg_t             cfg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [DB_W-1:0] out_gain
);

    typedef enum logic [1:0] {
        RGN_ZERO,
        RGN_KNEE,
        RGN_ABOVE
    } region_t;

    localparam int O_W        = DB_W + 1;
    localparam int TW         = O_W + 1;
    localparam int U_W        = KNEE_W + 1;
    localparam int SQ_W       = 2 * U_W;
    localparam int PROD_W     = SLOPE_W + SQ_W;
    localparam int Q_BITS     = 13;
    localparam int DNUM_W     = KNEE_W + Q_BITS;
    localparam int KNEE_SHIFT = 19;
    localparam int ABOVE_SHIFT = 16;
    localparam int GMAG_W     = DB_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STG    = (Q_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_BASE   = 4;
    localparam int NSTG       = DIV_BASE + DIV_STG + 1;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   adv;

    logic signed [O_W-1:0] over;
    logic signed [TW-1:0]  two_over;
    logic signed [TW-1:0]  kw_s;
    region_t               rgn1_reg, rgn1_next;
    logic [U_W-1:0]        u1_reg, u1_next;
    logic [DB_W-1:0]       opos1_reg;

    region_t               rgn2_reg;
    logic [SQ_W-1:0]       sq2_reg, sq2_next;
    logic [DB_W-1:0]       opos2_reg;

    region_t               rgn3_reg;
    logic [SQ_W-1:0]       mul_op;
    logic [PROD_W-1:0]     prod3_reg, prod3_next;

    logic [PROD_W:0]       dsum;
    logic [DNUM_W-1:0]     dnum;
    logic [PROD_W:0]       asum;
    logic [PROD_W:0]       above_mag;
    logic [GMAG_W-1:0]     res_next;

    region_t               rgn_reg [DIV_STG+1];
    logic [GMAG_W-1:0]     res_reg [DIV_STG+1];
    logic [KNEE_W-1:0]     rem_reg [DIV_STG+1];
    logic [Q_BITS-1:0]     dvd_reg [DIV_STG+1];
    logic [Q_BITS-1:0]     q_reg   [DIV_STG+1];

    logic [GMAG_W-1:0]     gmag;
    logic signed [DB_W-1:0] gain_reg, gain_next;

    always_comb begin
        adv[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Region select: the knee spans -K < 2o <= K, so a zero knee never selects it.
    always_comb begin
        over     = O_W'(in_level) - O_W'(cfg.threshold);
        two_over = $signed({over, 1'b0});
        kw_s     = TW'(cfg.knee);
        if (two_over <= -kw_s) begin
            rgn1_next = RGN_ZERO;
        end else if (two_over <= kw_s) begin
            rgn1_next = RGN_KNEE;
        end else begin
            rgn1_next = RGN_ABOVE;
        end
        u1_next = U_W'(two_over + kw_s);

        sq2_next = SQ_W'(u1_reg) * SQ_W'(u1_reg);

        mul_op     = (rgn2_reg == RGN_KNEE) ? sq2_reg : SQ_W'(opos2_reg);
        prod3_next = PROD_W'(cfg.slope) * PROD_W'(mul_op);

        // Knee: round(num / (K * 2^19)) = floor(floor((num + K*2^18) / 2^19) / K).
        dsum = (PROD_W + 1)'(prod3_reg) + ((PROD_W + 1)'(cfg.knee) << (KNEE_SHIFT - 1));
        dnum = DNUM_W'(dsum >> KNEE_SHIFT);

        asum      = (PROD_W + 1)'(prod3_reg) + (PROD_W + 1)'(64'd1 << (ABOVE_SHIFT - 1));
        above_mag = asum >> ABOVE_SHIFT;
        case (rgn3_reg)
            RGN_ABOVE: res_next = (above_mag > (PROD_W + 1)'(GAIN_MAX)) ? GMAG_W'(GAIN_MAX)
                                                                       : above_mag[GMAG_W-1:0];
            default:   res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            rgn1_reg  <= rgn1_next;
            u1_reg    <= u1_next;
            opos1_reg <= over[DB_W-1:0];
        end
        if (adv[1]) begin
            rgn2_reg  <= rgn1_reg;
            sq2_reg   <= sq2_next;
            opos2_reg <= opos1_reg;
        end
        if (adv[2]) begin
            rgn3_reg  <= rgn2_reg;
            prod3_reg <= prod3_next;
        end
        if (adv[3]) begin
            rgn_reg[0] <= rgn3_reg;
            res_reg[0] <= res_next;
            rem_reg[0] <= dnum[DNUM_W-1:Q_BITS];
            dvd_reg[0] <= dnum[Q_BITS-1:0];
            q_reg[0]   <= '0;
        end
    end

    // Knee quotient never exceeds K/2 + 1, so Q_BITS bits and a remainder below K suffice.
    for (genvar s = 0; s < DIV_STG; s++) begin : g_div
        logic [KNEE_W-1:0] rem_next;
        logic [Q_BITS-1:0] dvd_next;
        logic [Q_BITS-1:0] q_next;
        logic [KNEE_W:0]   trial;

        always_comb begin
            rem_next = rem_reg[s];
            dvd_next = dvd_reg[s];
            q_next   = q_reg[s];
            trial    = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < Q_BITS) begin
                    trial    = {rem_next, dvd_next[Q_BITS-1]};
                    dvd_next = {dvd_next[Q_BITS-2:0], 1'b0};
                    if (trial >= {1'b0, cfg.knee}) begin
                        rem_next = KNEE_W'(trial - {1'b0, cfg.knee});
                        q_next   = {q_next[Q_BITS-2:0], 1'b1};
                    end else begin
                        rem_next = trial[KNEE_W-1:0];
                        q_next   = {q_next[Q_BITS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[DIV_BASE+s]) begin
                rgn_reg[s+1] <= rgn_reg[s];
                res_reg[s+1] <= res_reg[s];
                rem_reg[s+1] <= rem_next;
                dvd_reg[s+1] <= dvd_next;
                q_reg[s+1]   <= q_next;
            end
        end
    end

    always_comb begin
        gmag      = (rgn_reg[DIV_STG] == RGN_KNEE) ? GMAG_W'(q_reg[DIV_STG])
                                                   : res_reg[DIV_STG];
        gain_next = ~gmag + GMAG_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTG-1]) begin
            gain_reg <= gain_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_gain  = gain_reg;

endmodule

// ===== rtl/soft_knee_gain_computer.sv =====
// Pipeline: 14 register stages from the accepted input beat to the presented result.
// Throughput: one beat per cycle, except while back-pressure or a slope recompute holds
// s_tready low; each stage holds its beat while the one below is full. A write to the
// ratio register recomputes the slope with a bit-serial divider, during which s_tready
// is low. Ratios above 23.9 take effect at once. Reset (aresetn low at a rising edge)
// empties the pipeline and restores the default threshold, ratio and knee width.
module soft_knee_gain_computer
    import skgc_pkg::*;
#(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,    // [23:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DB_W-1:0]        m_tdata,    // [15:0] gain_reduction_db
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic signed [DB_W-1:0] threshold_reg;
    logic [KNEE_W-1:0]      knee_reg;
    logic                   cfg_we;
    logic                   ratio_we;

    slope_stat_t            slope_stat;
    curve_cfg_t             curve_cfg;

    logic                   lvl_in_valid;
    logic                   lvl_in_ready;
    logic                   lvl_valid;
    logic                   lvl_ready;
    logic signed [DB_W-1:0] lvl_db;
    logic signed [DB_W-1:0] gain_db;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign ratio_we  = cfg_we && (cfg_index == REG_RATIO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            knee_reg      <= KNEE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_KNEE:      knee_reg      <= cfg_data[KNEE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    skgc_slope_div u_slope_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ratio_we),
        .ratio   (cfg_data[RATIO_W-1:0]),
        .stat    (slope_stat)
    );

    assign curve_cfg.threshold = threshold_reg;
    assign curve_cfg.knee      = knee_reg;
    assign curve_cfg.slope     = slope_stat.mag;

    assign lvl_in_valid = s_tvalid && !slope_stat.busy;
    assign s_tready     = lvl_in_ready && !slope_stat.busy;

    skgc_level #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lvl_in_valid),
        .in_ready  (lvl_in_ready),
        .in_sample (s_tdata),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_level (lvl_db)
    );

    skgc_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lvl_valid),
        .in_ready  (lvl_ready),
        .in_level  (lvl_db),
        .cfg       (curve_cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gain  (gain_db)
    );

    assign m_tdata = gain_db;

    a_gain_not_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DB_W-1] || m_tdata == '0))
        else $error("gain reduction is positive");

    a_no_accept_while_slope_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        slope_stat.busy |-> !s_tready)
        else $error("input accepted while slope is recomputed");

    a_ratio_write_starts_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        (ratio_we && cfg_data[RATIO_W-1:0] >= RATIO_W'(RATIO_MIN)
                  && cfg_data[RATIO_W-1:0] < RATIO_W'(RATIO_LIMIT)) |=> slope_stat.busy)
        else $error("ratio write did not start the slope divider");

    a_slope_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !slope_stat.busy |-> (slope_stat.mag <= SLOPE_W'(SLOPE_ONE)))
        else $error("slope magnitude above one");

endmodule
